FILE: src/cne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator package
// Shared widths, register indexes, the queue entry type and helper functions.
// ----------------------------------------------------------------------------
package cne_pkg;

  localparam int MAX_CELLS_PER_AXIS = 64;

  localparam int CFG_W   = 7;
  localparam int CELL_W  = 18;
  localparam int POS_W   = 5;
  localparam int MAX_RUN = 27;

  localparam int CNT_W   = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int CRD_W   = (MAX_CELLS_PER_AXIS > 1) ? $clog2(MAX_CELLS_PER_AXIS) : 1;
  localparam int STEP_W  = (CRD_W > 1) ? $clog2(CRD_W) : 1;
  localparam int PLANE_W = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS + 1);
  localparam int TOTAL_W = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS
                                  * MAX_CELLS_PER_AXIS + 1);
  localparam int IDX_W   = (TOTAL_W > CELL_W) ? TOTAL_W : CELL_W;
  localparam int SHIFT_W = PLANE_W + CRD_W;
  localparam int DIV_W   = (SHIFT_W > IDX_W) ? SHIFT_W : IDX_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;

  localparam logic [REG_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [REG_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [REG_W-1:0] REG_CELLS_Z = 2'd2;

  // Neighbour offsets -1, 0 and +1 are held as indexes 0, 1 and 2.
  localparam int OFS_W   = 2;
  localparam int OFS_NUM = 3;
  localparam logic [OFS_W-1:0] OFS_MINUS = 2'd0;
  localparam logic [OFS_W-1:0] OFS_ZERO  = 2'd1;
  localparam logic [OFS_W-1:0] OFS_PLUS  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] nx;
    logic [CNT_W-1:0] ny;
    logic [CNT_W-1:0] nz;
  } grid_t;

  typedef struct packed {
    logic                              err;
    logic [OFS_NUM-1:0][CRD_W-1:0]     x_val;
    logic [OFS_NUM-1:0][PLANE_W-1:0]   z_term;
    logic [OFS_NUM-1:0][TOTAL_W-1:0]   y_term;
  } entry_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_CELLS_PER_AXIS) begin
      r = CNT_W'(MAX_CELLS_PER_AXIS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] axis_first(input logic [CNT_W-1:0] n);
    return (int'(n) >= 3) ? OFS_MINUS : OFS_ZERO;
  endfunction

  function automatic logic [OFS_W-1:0] axis_span(input logic [CNT_W-1:0] n);
    logic [OFS_W-1:0] r;
    if (int'(n) >= 3) begin
      r = OFS_W'(2);
    end else if (int'(n) == 2) begin
      r = OFS_W'(1);
    end else begin
      r = OFS_W'(0);
    end
    return r;
  endfunction

endpackage

FILE: src/cell_neighbourhood_enumerator.sv
`timescale 1ns / 1ps
// Flow: a center cell passes the front-end states (total, check, two divisions, push),
// the entry queue and the back-end output register; an out-of-range index skips the divisions.
// Throughput: one result per cycle while out_ready_i is high and the queue holds entries; a
// new center cell is taken only after the front end has pushed its previous entry, so the
// shared restoring divider in the front end works on one center cell at a time.
// Reset: cell counts return to 1, the queue empties and no result is valid.
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator top level
// Holds the grid size registers behind the APB port and connects the front end,
// the entry queue and the enumeration back end.
// ----------------------------------------------------------------------------
module cell_neighbourhood_enumerator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cne_pkg::PADDR_W-1:0] paddr,
  input  logic [cne_pkg::PDATA_W-1:0] pwdata,
  output logic [cne_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [cne_pkg::CELL_W-1:0]  center_cell_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cne_pkg::CELL_W-1:0]  neighbour_cell_o,
  output logic [cne_pkg::POS_W-1:0]   list_position_o,
  output logic                        is_last_o,
  output logic                        index_error_o
);
  import cne_pkg::*;

  logic [CFG_W-1:0] cells_x_q, cells_y_q, cells_z_q;
  logic [REG_W-1:0] reg_idx;
  logic             cfg_write;
  grid_t            grid;
  logic             push_valid, push_ready;
  entry_t           push_entry;
  logic             head_valid, pop;
  entry_t           head_entry;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CFG_W'(1);
      cells_y_q <= CFG_W'(1);
      cells_z_q <= CFG_W'(1);
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_CELLS_X: cells_x_q <= pwdata[CFG_W-1:0];
        REG_CELLS_Y: cells_y_q <= pwdata[CFG_W-1:0];
        REG_CELLS_Z: cells_z_q <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELLS_X: prdata = PDATA_W'(cells_x_q);
      REG_CELLS_Y: prdata = PDATA_W'(cells_y_q);
      REG_CELLS_Z: prdata = PDATA_W'(cells_z_q);
      default:     prdata = '0;
    endcase
  end

  assign grid.nx = eff_count(cells_x_q);
  assign grid.ny = eff_count(cells_y_q);
  assign grid.nz = eff_count(cells_z_q);

  cne_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_i        (grid),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .center_cell_i (center_cell_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  cne_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (pop),
    .pop_entry_o  (head_entry)
  );

  cne_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grid_i           (grid),
    .head_valid_i     (head_valid),
    .head_entry_i     (head_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neighbour_cell_o (neighbour_cell_o),
    .list_position_o  (list_position_o),
    .is_last_o        (is_last_o),
    .index_error_o    (index_error_o)
  );

endmodule

FILE: src/cne_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator front end
// Accepts a center cell, checks it against the cell total, splits an in-range
// cell into coordinates with a shared restoring divider and prepares the wrapped
// coordinate terms of every neighbour offset.
// ----------------------------------------------------------------------------
module cne_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cne_pkg::grid_t            grid_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [cne_pkg::CELL_W-1:0] center_cell_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output cne_pkg::entry_t           push_entry_o
);
  import cne_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_CHECK,
    ST_DIV_Y,
    ST_DIV_Z,
    ST_PUSH
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q;
  logic [PLANE_W-1:0]  plane_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [DIV_W-1:0]    rem_q;
  logic [DIV_W-1:0]    div_q;
  logic [STEP_W-1:0]   step_q;
  logic [CRD_W-1:0]    qy_q;
  logic [CRD_W-1:0]    qz_q;
  logic [PLANE_W-1:0]  remy_q;
  logic [TOTAL_W-1:0]  ybase_q;
  logic                err_q;

  logic                ge;
  logic [DIV_W-1:0]    rem_step;
  logic [CRD_W-1:0]    cx;
  logic [PLANE_W-1:0]  zbase;
  logic [PLANE_W-1:0]  nx_p;
  logic [TOTAL_W-1:0]  plane_t;

  assign ge       = rem_q >= div_q;
  assign rem_step = ge ? (rem_q - div_q) : rem_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_TOTAL;
      ST_TOTAL: state_d = ST_CHECK;
      ST_CHECK: state_d = (idx_q >= IDX_W'(total_q)) ? ST_PUSH : ST_DIV_Y;
      ST_DIV_Y: if (step_q == '0) state_d = ST_DIV_Z;
      ST_DIV_Z: if (step_q == '0) state_d = ST_PUSH;
      ST_PUSH:  if (push_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          idx_q   <= IDX_W'(center_cell_i);
          plane_q <= PLANE_W'(grid_i.nx) * PLANE_W'(grid_i.nz);
        end
      end
      ST_TOTAL: begin
        total_q <= TOTAL_W'(plane_q) * TOTAL_W'(grid_i.ny);
        rem_q   <= DIV_W'(idx_q);
        div_q   <= DIV_W'(plane_q) << (CRD_W - 1);
        step_q  <= STEP_W'(CRD_W - 1);
      end
      ST_CHECK: begin
        err_q <= idx_q >= IDX_W'(total_q);
      end
      ST_DIV_Y: begin
        rem_q  <= rem_step;
        qy_q   <= CRD_W'({qy_q, ge});
        if (step_q == '0) begin
          remy_q <= PLANE_W'(rem_step);
          div_q  <= DIV_W'(grid_i.nx) << (CRD_W - 1);
          step_q <= STEP_W'(CRD_W - 1);
        end else begin
          step_q <= step_q - STEP_W'(1);
          div_q  <= div_q >> 1;
        end
      end
      ST_DIV_Z: begin
        rem_q   <= rem_step;
        qz_q    <= CRD_W'({qz_q, ge});
        step_q  <= step_q - STEP_W'(1);
        div_q   <= div_q >> 1;
        ybase_q <= TOTAL_W'(idx_q - IDX_W'(remy_q));
      end
      ST_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  assign cx      = CRD_W'(rem_q);
  assign nx_p    = PLANE_W'(grid_i.nx);
  assign plane_t = TOTAL_W'(plane_q);
  assign zbase   = remy_q - PLANE_W'(cx);

  always_comb begin
    push_entry_o     = '0;
    push_entry_o.err = err_q;

    push_entry_o.x_val[OFS_MINUS] = (cx == '0) ? CRD_W'(grid_i.nx - CNT_W'(1))
                                               : cx - CRD_W'(1);
    push_entry_o.x_val[OFS_ZERO]  = cx;
    push_entry_o.x_val[OFS_PLUS]  = ((CNT_W'(cx) + CNT_W'(1)) >= grid_i.nx) ? '0
                                                                          : cx + CRD_W'(1);

    push_entry_o.z_term[OFS_MINUS] = (qz_q == '0) ? plane_q - nx_p : zbase - nx_p;
    push_entry_o.z_term[OFS_ZERO]  = zbase;
    push_entry_o.z_term[OFS_PLUS]  = ((CNT_W'(qz_q) + CNT_W'(1)) >= grid_i.nz) ? '0
                                                                             : zbase + nx_p;

    push_entry_o.y_term[OFS_MINUS] = (qy_q == '0) ? total_q - plane_t : ybase_q - plane_t;
    push_entry_o.y_term[OFS_ZERO]  = ybase_q;
    push_entry_o.y_term[OFS_PLUS]  = ((CNT_W'(qy_q) + CNT_W'(1)) >= grid_i.ny) ? '0
                                                                             : ybase_q + plane_t;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign push_valid_o = (state_q == ST_PUSH);

endmodule

FILE: src/cne_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator queue
// Short first-in first-out buffer of prepared entries between the front end
// and the enumeration back end.
// ----------------------------------------------------------------------------
module cne_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cne_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cne_pkg::entry_t pop_entry_o
);
  import cne_pkg::*;

  entry_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;
  assign pop_entry_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: src/cne_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator back end
// Walks the offsets of the head entry in x, y, z order, adds the prepared
// terms into a cell index and drives one result per cycle, while results are
// taken and an entry waits, through an output register.
// ----------------------------------------------------------------------------
module cne_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cne_pkg::grid_t             grid_i,
  input  logic                       head_valid_i,
  input  cne_pkg::entry_t            head_entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cne_pkg::CELL_W-1:0] neighbour_cell_o,
  output logic [cne_pkg::POS_W-1:0]  list_position_o,
  output logic                       is_last_o,
  output logic                       index_error_o
);
  import cne_pkg::*;

  logic [OFS_W-1:0]   rx_q, ry_q, rz_q;
  logic [OFS_W-1:0]   lx, ly, lz;
  logic [OFS_W-1:0]   ox, oy, oz;
  logic [POS_W-1:0]   pos_q;
  logic               out_valid_q;
  logic [CELL_W-1:0]  cell_q;
  logic [POS_W-1:0]   pos_out_q;
  logic               last_q;
  logic               err_q;
  logic               run_end;
  logic               load;
  logic [TOTAL_W-1:0] cell_sum;

  assign lx = axis_span(grid_i.nx);
  assign ly = axis_span(grid_i.ny);
  assign lz = axis_span(grid_i.nz);
  assign ox = rx_q + axis_first(grid_i.nx);
  assign oy = ry_q + axis_first(grid_i.ny);
  assign oz = rz_q + axis_first(grid_i.nz);

  assign run_end  = head_entry_i.err || ((rx_q == lx) && (ry_q == ly) && (rz_q == lz));
  assign load     = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = load && run_end;
  assign cell_sum = TOTAL_W'(head_entry_i.x_val[ox]) + TOTAL_W'(head_entry_i.z_term[oz])
                  + head_entry_i.y_term[oy];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rx_q        <= '0;
      ry_q        <= '0;
      rz_q        <= '0;
      pos_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      if (run_end) begin
        rx_q  <= '0;
        ry_q  <= '0;
        rz_q  <= '0;
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + POS_W'(1);
        if (rz_q == lz) begin
          rz_q <= '0;
          if (ry_q == ly) begin
            ry_q <= '0;
            rx_q <= rx_q + OFS_W'(1);
          end else begin
            ry_q <= ry_q + OFS_W'(1);
          end
        end else begin
          rz_q <= rz_q + OFS_W'(1);
        end
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_q    <= head_entry_i.err ? '0 : CELL_W'(cell_sum);
      pos_out_q <= pos_q;
      last_q    <= run_end;
      err_q     <= head_entry_i.err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign neighbour_cell_o = cell_q;
  assign list_position_o  = pos_out_q;
  assign is_last_o        = last_q;
  assign index_error_o    = err_q;

endmodule

FILE: src/cne_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator checker
// Port-level checks on result numbering, run ends, error results and stalled results.
// ----------------------------------------------------------------------------
module cne_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [cne_pkg::CELL_W-1:0]  neighbour_cell_o,
  input logic [cne_pkg::POS_W-1:0]   list_position_o,
  input logic                        is_last_o,
  input logic                        index_error_o
);
  import cne_pkg::*;

  logic [POS_W-1:0] exp_pos_q;

  // The expected position advances on every result transfer and restarts after a run end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_pos_q <= is_last_o ? '0 : list_position_o + POS_W'(1);
    end
  end

  a_pos_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_position_o == exp_pos_q)
    else $error("list position out of sequence");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (list_position_o == POS_W'(MAX_RUN - 1)) |-> is_last_o)
    else $error("run longer than the full neighbourhood");

  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |->
      is_last_o && (list_position_o == '0) && (neighbour_cell_o == '0))
    else $error("malformed index error result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(neighbour_cell_o) && $stable(list_position_o))
    else $error("stalled result changed");

endmodule

bind cell_neighbourhood_enumerator cne_checker u_cne_checker (.*);

FILE: tb/sv/cell_neighbourhood_enumerator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell neighbourhood enumerator testbench
// Programs grid sizes over APB and sends center cells with random gaps while
// the result side stalls at random. Every result transfer is checked against
// neighbour lists predicted from the programmed grid. A short directed part
// covers the reset grid, clamped and zero counts, one- and two-cell axes,
// out-of-range indexes and the full 64 x 64 x 64 grid, before random grids.
// ----------------------------------------------------------------------------
module cell_neighbourhood_enumerator_test;
  import cne_pkg::*;

  localparam int  DRAIN_CYCLES = 24;
  localparam int  RANDOM_ITEMS = 344;
  localparam longint CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [CELL_W-1:0] cell_id;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              err;
  } nbr_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CELL_W-1:0]   center_cell_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [CELL_W-1:0]   neighbour_cell_o;
  logic [POS_W-1:0]    list_position_o;
  logic                is_last_o;
  logic                index_error_o;

  logic [CFG_W-1:0] grid_x;
  logic [CFG_W-1:0] grid_y;
  logic [CFG_W-1:0] grid_z;
  nbr_t             neighbour_q[$];
  nbr_t             want_nbr;
  nbr_t             got_nbr;
  int               fail_count;
  bit               gaps_on;
  bit               stalls_on;
  int               ready_left;
  int               ready_gap;
  longint           cycle_count;

  cell_neighbourhood_enumerator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .center_cell_i    (center_cell_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .neighbour_cell_o (neighbour_cell_o),
    .list_position_o  (list_position_o),
    .is_last_o        (is_last_o),
    .index_error_o    (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int eff_cells(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > MAX_CELLS_PER_AXIS) begin
      return MAX_CELLS_PER_AXIS;
    end
    return int'(v);
  endfunction

  function automatic int axis_lo(input int n);
    return (n >= 3) ? -1 : 0;
  endfunction

  function automatic int axis_hi(input int n);
    return (n >= 2) ? 1 : 0;
  endfunction

  function automatic int wrap_axis(input int c, input int off, input int n);
    if (off < 0) begin
      return (c == 0) ? n - 1 : c - 1;
    end
    if (off > 0) begin
      return (c + 1 >= n) ? 0 : c + 1;
    end
    return c;
  endfunction

  function automatic int grid_total();
    return eff_cells(grid_x) * eff_cells(grid_y) * eff_cells(grid_z);
  endfunction

  function automatic void predict_neighbours(input logic [CELL_W-1:0] center);
    int   nx, ny, nz, plane, cx, cy, cz, rem, run_len, count, i, j, k;
    nbr_t e;
    nx    = eff_cells(grid_x);
    ny    = eff_cells(grid_y);
    nz    = eff_cells(grid_z);
    plane = nx * nz;
    if (int'(center) >= plane * ny) begin
      e = '{cell_id: '0, pos: '0, last: 1'b1, err: 1'b1};
      neighbour_q.push_back(e);
      return;
    end
    cy      = int'(center) / plane;
    rem     = int'(center) - cy * plane;
    cz      = rem / nx;
    cx      = rem - cz * nx;
    run_len = (axis_hi(nx) - axis_lo(nx) + 1) * (axis_hi(ny) - axis_lo(ny) + 1)
              * (axis_hi(nz) - axis_lo(nz) + 1);
    count   = 0;
    for (i = axis_lo(nx); i <= axis_hi(nx); i++) begin
      for (j = axis_lo(ny); j <= axis_hi(ny); j++) begin
        for (k = axis_lo(nz); k <= axis_hi(nz); k++) begin
          e.cell_id = CELL_W'(wrap_axis(cx, i, nx) + wrap_axis(cz, k, nz) * nx
                              + wrap_axis(cy, j, ny) * plane);
          e.pos     = POS_W'(count);
          e.last    = (count == run_len - 1);
          e.err     = 1'b0;
          neighbour_q.push_back(e);
          count++;
        end
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end
    if (r < 20) begin
      return CFG_W'(1);
    end
    if (r < 32) begin
      return CFG_W'(2);
    end
    if (r < 82) begin
      return CFG_W'($urandom_range(3, 8));
    end
    if (r < 92) begin
      return CFG_W'($urandom_range(9, 64));
    end
    return CFG_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [CELL_W-1:0] pick_center();
    int total, r;
    total = grid_total();
    r     = $urandom_range(0, 99);
    if (r < 75) begin
      return CELL_W'($urandom_range(0, total - 1));
    end
    if (r < 85 && total <= 262143) begin
      return CELL_W'($urandom_range(total, 262143));
    end
    if (r < 92) begin
      return (r % 2 == 0) ? '0 : CELL_W'(total - 1);
    end
    return CELL_W'($urandom());
  endfunction

  // Ready pattern on the result side: bursts high, random stalls low.
  always @(posedge clk_i) begin
    if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else if (!stalls_on || !out_ready_i) begin
      out_ready_i <= 1'b1;
      ready_left = $urandom_range(0, 12);
    end else begin
      ready_gap = pick_gap();
      if (ready_gap > 0) begin
        out_ready_i <= 1'b0;
        ready_left = ready_gap - 1;
      end else begin
        ready_left = $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_nbr = '{cell_id: neighbour_cell_o, pos: list_position_o,
                  last: is_last_o, err: index_error_o};
      if (neighbour_q.size() == 0) begin
        $display("%0t unexpected result transfer: expected nothing, actual cell %0d pos %0d",
                 $time, got_nbr.cell_id, got_nbr.pos);
        $display("%0t   actual last %0b err %0b", $time, got_nbr.last, got_nbr.err);
        fail_count++;
      end else begin
        want_nbr = neighbour_q.pop_front();
        if (got_nbr !== want_nbr) begin
          $display("%0t result mismatch: expected cell %0d pos %0d last %0b err %0b,",
                   $time, want_nbr.cell_id, want_nbr.pos, want_nbr.last, want_nbr.err);
          $display("%0t   actual cell %0d pos %0d last %0b err %0b",
                   $time, got_nbr.cell_id, got_nbr.pos, got_nbr.last, got_nbr.err);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_center(input logic [CELL_W-1:0] center);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    center_cell_i <= center;
    do @(posedge clk_i); while (!in_ready_o);
    predict_neighbours(center);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (neighbour_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_W-1:0] idx, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {(PDATA_W - CFG_W)'($urandom_range(0, 33554431)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CELLS_X: grid_x = val;
      REG_CELLS_Y: grid_y = val;
      REG_CELLS_Z: grid_z = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                          input logic [CFG_W-1:0] z);
    wait_idle();
    write_reg(REG_CELLS_X, x);
    write_reg(REG_CELLS_Y, y);
    write_reg(REG_CELLS_Z, z);
  endtask

  task automatic test_reset_grid();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_center('0);
    send_center(CELL_W'(1));
    send_center('1);
  endtask

  task automatic test_clamped_counts();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_grid(CFG_W'(127), '0, CFG_W'(65));
    send_center('0);
    send_center(CELL_W'(4095));
    send_center(CELL_W'(4096));
    send_center('1);
  endtask

  task automatic test_short_axes();
    int c;
    set_grid(CFG_W'(2), CFG_W'(2), CFG_W'(2));
    for (c = 0; c <= 8; c++) begin
      send_center(CELL_W'(c));
    end
    set_grid(CFG_W'(1), CFG_W'(2), CFG_W'(3));
    send_center('0);
    send_center(CELL_W'(5));
    send_center(CELL_W'(6));
    set_grid(CFG_W'(3), CFG_W'(3), CFG_W'(3));
    send_center(CELL_W'(13));
    send_center(CELL_W'(26));
  endtask

  task automatic test_full_grid();
    set_grid(CFG_W'(64), CFG_W'(64), CFG_W'(64));
    send_center('0);
    send_center('1);
    send_center(CELL_W'(18'h15555));
    send_center(CELL_W'(18'h2AAAA));
    send_center(CELL_W'(4095));
  endtask

  task automatic test_random_grids();
    int sent, n, burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_grid(pick_count(), pick_count(), pick_count());
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      burst     = $urandom_range(15, 45);
      for (n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
        send_center(pick_center());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    center_cell_i = '0;
    out_ready_i   = 1'b0;
    grid_x        = CFG_W'(1);
    grid_y        = CFG_W'(1);
    grid_z        = CFG_W'(1);
    fail_count    = 0;
    gaps_on       = 1'b0;
    stalls_on     = 1'b0;
    ready_left    = 0;
    cycle_count   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_grid();
    test_clamped_counts();
    test_short_axes();
    test_full_grid();
    test_random_grids();
    wait_idle();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/cne_pkg.sv
src/cne_front.sv
src/cne_queue.sv
src/cne_back.sv
src/cell_neighbourhood_enumerator.sv
src/cne_checker.sv
tb/sv/cell_neighbourhood_enumerator_test.sv
